[src/qcldpc_pkg.sv]
// Package with the base matrix, circulant helpers and opcodes of the QC-LDPC encoder and checker.
`timescale 1ns / 1ps

package qcldpc_pkg;

	localparam int CIRC      = 5;
	localparam int MSG_BITS  = 20;
	localparam int CW_BITS   = 40;
	localparam int SYN_BITS  = 20;
	localparam int BLK_ROWS  = 4;
	localparam int BLK_COLS  = 8;
	localparam int MSG_BLKS  = 4;

	typedef enum logic {
		OP_ENCODE = 1'b0,
		OP_CHECK  = 1'b1
	} opcode_t;

	typedef logic [2:0]         shift_t;
	typedef logic [CIRC-1:0]    blk_t;
	typedef logic [CW_BITS-1:0] word_t;

	// Marks an all-zero block in the base matrix.
	localparam shift_t NOBLK = 3'd7;

	localparam shift_t SHIFT_TAB [BLK_ROWS][BLK_COLS] = '{
		'{3'd1, NOBLK, 3'd3, 3'd1, 3'd2, 3'd0, NOBLK, NOBLK},
		'{3'd2, 3'd0, NOBLK, 3'd3, NOBLK, 3'd0, 3'd0, NOBLK},
		'{NOBLK, 3'd4, 3'd2, 3'd3, 3'd1, NOBLK, 3'd0, 3'd0},
		'{3'd4, 3'd1, 3'd0, NOBLK, 3'd2, NOBLK, NOBLK, 3'd0}
	};

	// Circulant I_s applied to a block: result bit i is v bit (i+s) mod 5.
	function automatic blk_t circ(blk_t v, shift_t s);
		blk_t res;
		int   idx;
		res = '0;
		for (int i = 0; i < CIRC; i++) begin
			idx = i + int'(s);
			if (idx >= CIRC) begin
				idx = idx - CIRC;
			end
			res[i] = v[idx];
		end
		return res;
	endfunction

	// XOR of the nonzero blocks of one block row over block columns lo..hi-1.
	function automatic blk_t row_terms(word_t w, int r, int lo, int hi);
		blk_t acc;
		acc = '0;
		for (int c = 0; c < BLK_COLS; c++) begin
			if (c >= lo && c < hi && SHIFT_TAB[r][c] != NOBLK) begin
				acc = acc ^ circ(w[CIRC*c +: CIRC], SHIFT_TAB[r][c]);
			end
		end
		return acc;
	endfunction

endpackage

[src/qc_ldpc_encode_and_check.sv]
// Top level of the rate-1/2 quasi-cyclic LDPC encoder and syndrome checker.
`timescale 1ns / 1ps

// Usage:
// The input channel (in_valid, in_ready) carries an opcode and a 40-bit word. With the
// encode opcode, bits 0-19 are the message and bits 20-39 are ignored; the block
// returns the systematic codeword (message, then parity blocks p1..p4). With the check
// opcode, the word is echoed on codeword. In both modes syndrome is H times the
// returned codeword over GF(2) and syndrome_parity is the XOR of its twenty bits, so
// an encoded word always shows an all-zero syndrome.
// The output channel (out_valid, out_ready) delivers exactly one result per input
// transfer, in order.
// An input transfer loads the input register; the result register then loads from it
// when it may advance and raises out_valid. The whole encode and syndrome XOR network
// sits between those two registers, so the block sustains one transfer per clock cycle
// while the receiver does not stall.
// When the receiver stalls, the result register holds its value and the input
// register can still take one more item; in_ready falls only when both are full.
// Reset (arst_n low) empties both registers at once; no result is pending after it.
module qc_ldpc_encode_and_check
	import qcldpc_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic                opcode,
	input  logic [CW_BITS-1:0]  word_in,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [CW_BITS-1:0]  codeword,
	output logic [SYN_BITS-1:0] syndrome,
	output logic                syndrome_parity
);

	// Input register.
	logic                v_s1;
	logic                opcode_s1;
	word_t               word_s1;

	// Result register.
	logic                v_s2;
	word_t               codeword_s2;
	logic [SYN_BITS-1:0] syndrome_s2;
	logic                parity_s2;

	logic                adv_s2;
	logic                take_in;

	word_t               msg_word;
	blk_t                s_sum;
	blk_t                p1;
	blk_t                p2;
	blk_t                p3;
	blk_t                p4;
	word_t               cw_d;
	logic [SYN_BITS-1:0] syn_d;

	// The result register may load when it is empty or its item leaves in this cycle.
	assign adv_s2   = !v_s2 || out_ready;
	assign in_ready = !v_s1 || adv_s2;
	assign take_in  = in_valid && in_ready;

	// Encoder by back-substitution, then the syndrome of the outgoing word.
	always_comb begin
		msg_word = {{(CW_BITS-MSG_BITS){1'b0}}, word_s1[MSG_BITS-1:0]};
		s_sum    = '0;
		for (int r = 0; r < BLK_ROWS; r++) begin
			s_sum = s_sum ^ row_terms(msg_word, r, 0, MSG_BLKS);
		end
		p1 = circ(s_sum, 3'd4);
		p2 = row_terms(msg_word, 0, 0, MSG_BLKS) ^ circ(p1, 3'd2);
		p3 = row_terms(msg_word, 1, 0, MSG_BLKS) ^ p2;
		p4 = row_terms(msg_word, 3, 0, MSG_BLKS) ^ circ(p1, 3'd2);

		if (opcode_s1 == OP_CHECK) begin
			cw_d = word_s1;
		end else begin
			cw_d = {p4, p3, p2, p1, word_s1[MSG_BITS-1:0]};
		end

		for (int r = 0; r < BLK_ROWS; r++) begin
			syn_d[CIRC*r +: CIRC] = row_terms(cw_d, r, 0, BLK_COLS);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (in_ready) begin
				v_s1 <= in_valid;
			end
			if (adv_s2) begin
				v_s2 <= v_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take_in) begin
			opcode_s1 <= opcode;
			word_s1   <= word_in;
		end
		if (adv_s2 && v_s1) begin
			codeword_s2 <= cw_d;
			syndrome_s2 <= syn_d;
			parity_s2   <= ^syn_d;
		end
	end

	assign out_valid       = v_s2;
	assign codeword        = codeword_s2;
	assign syndrome        = syndrome_s2;
	assign syndrome_parity = parity_s2;

endmodule

[src/qcldpc_checker.sv]
// Port-level assertions for the QC-LDPC encoder and checker, bound to the top level.
`timescale 1ns / 1ps

module qcldpc_checker
	import qcldpc_pkg::*;
(
	input logic                clk,
	input logic                arst_n,
	input logic                in_valid,
	input logic                in_ready,
	input logic                opcode,
	input logic [CW_BITS-1:0]  word_in,
	input logic                out_valid,
	input logic                out_ready,
	input logic [CW_BITS-1:0]  codeword,
	input logic [SYN_BITS-1:0] syndrome,
	input logic                syndrome_parity
);

	// A waiting input item keeps its payload until it is taken.
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_ready |=> in_valid && $stable(opcode) && $stable(word_in))
		else $error("input changed while waiting");

	// A stalled result keeps its payload.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(codeword) && $stable(syndrome))
		else $error("result changed while stalled");

	// The parity output agrees with the syndrome shown next to it whenever a result is valid.
	a_parity: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> syndrome_parity == ^syndrome)
		else $error("syndrome parity mismatch");

	// Back-pressure only comes from a full, stalled output.
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid && !out_ready)
		else $error("input stalled without an output stall");

	// An accepted item reaches the output if the receiver is ready in between.
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) ##1 out_ready |=> out_valid)
		else $error("accepted item did not arrive at the output");

endmodule

bind qc_ldpc_encode_and_check qcldpc_checker u_qcldpc_checker (.*);

[tb/tb_qc_ldpc_encode_and_check.sv]
// Testbench for the QC-LDPC encoder and syndrome checker, with its own predictor.
`timescale 1ns / 1ps

module tb_qc_ldpc_encode_and_check;
	import qcldpc_pkg::*;

	// Generous bound: about 1600 items, each at worst a long sender gap plus a long
	// receiver stall, taken several times over.
	localparam int CYCLE_LIMIT = 1000000;
	localparam int NO_CIRC     = -1;

	// Base matrix shifts per block row; NO_CIRC marks an all-zero block.
	localparam int HSHIFT [4][8] = '{
		'{1, NO_CIRC, 3, 1, 2, 0, NO_CIRC, NO_CIRC},
		'{2, 0, NO_CIRC, 3, NO_CIRC, 0, 0, NO_CIRC},
		'{NO_CIRC, 4, 2, 3, 1, NO_CIRC, 0, 0},
		'{4, 1, 0, NO_CIRC, 2, NO_CIRC, NO_CIRC, 0}
	};

	typedef struct packed {
		logic [CW_BITS-1:0]  cw;
		logic [SYN_BITS-1:0] syn;
		logic                par;
	} ldpc_result_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                in_valid = 1'b0;
	logic                in_ready;
	logic                opcode = OP_ENCODE;
	logic [CW_BITS-1:0]  word_in = '0;
	logic                out_valid;
	logic                out_ready = 1'b0;
	logic [CW_BITS-1:0]  codeword;
	logic [SYN_BITS-1:0] syndrome;
	logic                syndrome_parity;

	ldpc_result_t pending_results [$];
	ldpc_result_t head_result;
	int           err_count = 0;
	int           cycle_count = 0;

	// Idling controls shared by the test tasks, the sender task and the receiver process.
	bit tx_idle_en = 1'b1;
	bit rx_idle_en = 1'b1;
	int rx_hold_len = 0;

	qc_ldpc_encode_and_check dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.opcode          (opcode),
		.word_in         (word_in),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.codeword        (codeword),
		.syndrome        (syndrome),
		.syndrome_parity (syndrome_parity)
	);

	always #4 clk = ~clk;

	// ------------------------------------------------------------------
	// Predictor: circulant rotation, block row sums and the encoder's
	// back-substitution, followed by the syndrome of the returned word.
	// ------------------------------------------------------------------

	// Circulant I_s on one 5-bit block: output bit i takes input bit (i+s) mod 5.
	function automatic logic [4:0] rot5(input logic [4:0] v, input int s);
		logic [4:0] r;
		for (int i = 0; i < 5; i++) begin
			r[i] = v[(i + s) % 5];
		end
		return r;
	endfunction

	// XOR over block columns lo..hi-1 of one block row applied to the word.
	function automatic logic [4:0] block_row_sum(input logic [CW_BITS-1:0] w, input int r,
			input int lo, input int hi);
		logic [4:0] acc;
		acc = '0;
		for (int c = lo; c < hi; c++) begin
			if (HSHIFT[r][c] != NO_CIRC) begin
				acc ^= rot5(w[5*c +: 5], HSHIFT[r][c]);
			end
		end
		return acc;
	endfunction

	function automatic ldpc_result_t ldpc_outcome(input opcode_t op,
			input logic [CW_BITS-1:0] w);
		ldpc_result_t res;
		logic [4:0]   s;
		logic [4:0]   p1;
		logic [4:0]   p2;
		logic [4:0]   p3;
		logic [4:0]   p4;
		if (op == OP_ENCODE) begin
			// Upper half of the input is don't-care in encode mode.
			res.cw = {20'd0, w[19:0]};
			s = '0;
			for (int r = 0; r < 4; r++) begin
				s ^= block_row_sum(res.cw, r, 0, 4);
			end
			p1 = rot5(s, 4);
			p2 = block_row_sum(res.cw, 0, 0, 4) ^ rot5(p1, 2);
			p3 = block_row_sum(res.cw, 1, 0, 4) ^ p2;
			p4 = block_row_sum(res.cw, 3, 0, 4) ^ rot5(p1, 2);
			res.cw[39:20] = {p4, p3, p2, p1};
		end else begin
			res.cw = w;
		end
		for (int r = 0; r < 4; r++) begin
			res.syn[5*r +: 5] = block_row_sum(res.cw, r, 0, 8);
		end
		res.par = ^res.syn;
		return res;
	endfunction

	// ------------------------------------------------------------------
	// Shared helpers for stimulus.
	// ------------------------------------------------------------------

	// Mostly short gaps, now and then a long one.
	function automatic int pick_gap();
		if ($urandom_range(0, 99) < 80) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(10, 40);
	endfunction

	function automatic logic [CW_BITS-1:0] rand_word();
		logic [CW_BITS-1:0] w;
		w[31:0]  = $urandom();
		w[39:32] = 8'($urandom_range(0, 255));
		return w;
	endfunction

	// Offers one item and returns at the rising edge where the transfer happens.
	// It is always called right after a rising edge. Handshake signals are sampled
	// at the falling edge, where every input and output of the block is settled.
	task automatic send_item(input opcode_t op, input logic [CW_BITS-1:0] w);
		int gap;
		if (tx_idle_en && $urandom_range(0, 99) < 20) begin
			gap = pick_gap();
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		opcode   <= op;
		word_in  <= w;
		do @(negedge clk); while (!in_ready);
		// The transfer takes place at the coming rising edge.
		pending_results.push_back(ldpc_outcome(op, w));
		@(posedge clk);
	endtask

	// Stops offering items and waits until every pending result has arrived.
	task automatic wait_drained();
		in_valid <= 1'b0;
		while (pending_results.size() != 0) begin
			@(posedge clk);
		end
	endtask

	// A random check-mode word: mostly a true codeword with a few flipped bits,
	// otherwise an arbitrary 40-bit word.
	function automatic logic [CW_BITS-1:0] noisy_codeword();
		ldpc_result_t clean;
		logic [CW_BITS-1:0] w;
		int flips;
		if ($urandom_range(0, 99) < 40) begin
			return rand_word();
		end
		clean = ldpc_outcome(OP_ENCODE, rand_word());
		w = clean.cw;
		flips = $urandom_range(0, 3);
		for (int i = 0; i < flips; i++) begin
			w[$urandom_range(0, CW_BITS-1)] ^= 1'b1;
		end
		return w;
	endfunction

	task automatic send_random(input int count);
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(0, 1) == 0) begin
				send_item(OP_ENCODE, rand_word());
			end else begin
				send_item(OP_CHECK, noisy_codeword());
			end
		end
	endtask

	// ------------------------------------------------------------------
	// Test tasks.
	// ------------------------------------------------------------------

	// Field extremes in both modes, garbage in the ignored upper half of an
	// encode request, clean codewords and single-bit errors.
	task automatic test_directed();
		ldpc_result_t clean;
		send_item(OP_ENCODE, 40'h00_0000_0000);
		send_item(OP_ENCODE, 40'h00_000F_FFFF);
		send_item(OP_ENCODE, 40'hFF_FFF0_0000);
		send_item(OP_ENCODE, 40'hFF_FFFF_FFFF);
		send_item(OP_ENCODE, 40'h55_555A_AAAA);
		send_item(OP_ENCODE, 40'hAA_AAA5_5555);
		send_item(OP_ENCODE, 40'h00_0000_0001);
		send_item(OP_ENCODE, 40'h00_0008_0000);
		send_item(OP_CHECK, 40'h00_0000_0000);
		send_item(OP_CHECK, 40'hFF_FFFF_FFFF);
		send_item(OP_CHECK, 40'h55_5555_5555);
		send_item(OP_CHECK, 40'hAA_AAAA_AAAA);
		clean = ldpc_outcome(OP_ENCODE, 40'h00_000F_FFFF);
		send_item(OP_CHECK, clean.cw);
		send_item(OP_CHECK, clean.cw ^ 40'h80_0000_0000);
		send_item(OP_CHECK, clean.cw ^ 40'h00_0000_0001);
		clean = ldpc_outcome(OP_ENCODE, 40'h00_0001_2345);
		send_item(OP_CHECK, clean.cw);
		send_item(OP_CHECK, clean.cw ^ 40'h00_0010_0000);
		send_item(OP_CHECK, 40'h00_0000_0001);
		send_item(OP_CHECK, 40'h80_0000_0000);
	endtask

	// Random traffic with idling on both sides.
	task automatic test_random_traffic();
		tx_idle_en = 1'b1;
		rx_idle_en = 1'b1;
		send_random(600);
		// The sender pauses here until the block has handed back everything.
		wait_drained();
		send_random(600);
	endtask

	// Back-to-back transfers with neither side idling, to exercise full rate.
	task automatic test_full_rate();
		tx_idle_en = 1'b0;
		rx_idle_en = 1'b0;
		send_random(250);
		tx_idle_en = 1'b1;
		rx_idle_en = 1'b1;
	endtask

	// The receiver holds off for a long stretch while the sender keeps offering
	// items, so both internal registers fill and in_ready falls.
	task automatic test_receiver_hold();
		tx_idle_en = 1'b0;
		rx_idle_en = 1'b0;
		rx_hold_len = 60;
		send_random(30);
		wait_drained();
		tx_idle_en = 1'b1;
		rx_idle_en = 1'b1;
		rx_hold_len = 80;
		send_random(100);
	endtask

	// ------------------------------------------------------------------
	// Receiver: drives out_ready with random stalls, or holds it low for a
	// requested number of cycles.
	// ------------------------------------------------------------------
	initial begin : receiver
		int stall;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (rx_hold_len > 0) begin
				stall = rx_hold_len;
				rx_hold_len = 0;
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
				out_ready <= 1'b1;
			end else if (rx_idle_en && $urandom_range(0, 99) < 20) begin
				stall = pick_gap();
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
				out_ready <= 1'b1;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// ------------------------------------------------------------------
	// Result checker: a result transfer at the coming rising edge is seen at
	// the falling edge before it, and compared with the oldest prediction.
	// ------------------------------------------------------------------
	always @(negedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected result, codeword %h syndrome %h parity %b",
					$time, codeword, syndrome, syndrome_parity);
				err_count++;
			end else begin
				head_result = pending_results.pop_front();
				if (codeword !== head_result.cw) begin
					$display("%0t: codeword mismatch, expected %h, actual %h",
						$time, head_result.cw, codeword);
					err_count++;
				end
				if (syndrome !== head_result.syn) begin
					$display("%0t: syndrome mismatch, expected %h, actual %h",
						$time, head_result.syn, syndrome);
					err_count++;
				end
				if (syndrome_parity !== head_result.par) begin
					$display("%0t: syndrome_parity mismatch, expected %b, actual %b",
						$time, head_result.par, syndrome_parity);
					err_count++;
				end
			end
		end
	end

	// Watchdog: counts cycles and ends a run that hangs.
	initial begin : watchdog
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("DONE: errors detected");
		$finish;
	end

	// ------------------------------------------------------------------
	// Main sequence: one reset, the test tasks in turn, then the final verdict.
	// ------------------------------------------------------------------
	initial begin : main_seq
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random_traffic();
		test_full_rate();
		test_receiver_hold();
		wait_drained();
		// The pipeline is two registers deep; the extra wait catches stray results.
		repeat (10) @(posedge clk);
		if (err_count == 0 && pending_results.size() == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule
